// ===== rtl/lbs_pkg.sv =====
// Shared types, constants and helper functions for the linear blend skinning block.
package lbs_pkg;

   localparam int BONE_COUNT   = 64;
   localparam int VALUE_WIDTH  = 32;
   localparam int BONE_WIDTH   = 6;
   localparam int ELEM_WIDTH   = 4;
   localparam int DATA_WIDTH   = 32;
   localparam int WEIGHT_WIDTH = 16;
   localparam int CMD_WIDTH    = 2;
   localparam int ADDR_WIDTH   = $clog2(BONE_COUNT * 16);
   localparam int OPND_WIDTH   = DATA_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * OPND_WIDTH;
   localparam int ACC_WIDTH    = 52;
   localparam int SUM_WIDTH    = 48;
   localparam int OUT_WIDTH    = 32;
   localparam int QUEUE_DEPTH  = 2;
   localparam int STEP_WIDTH   = 7;

   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_WORLD = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_INV   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_ATTACH     = 2'd2;

   localparam logic [1:0] SRC_INPUT     = 2'd0;
   localparam logic [1:0] SRC_MATRIX    = 2'd1;
   localparam logic [1:0] SRC_TRANSLATE = 2'd2;
   localparam logic [1:0] SRC_LINEAR    = 2'd3;

   localparam logic [2:0] DST_WPOS     = 3'd0;
   localparam logic [2:0] DST_WNORM    = 3'd1;
   localparam logic [2:0] DST_DELTA    = 3'd2;
   localparam logic [2:0] DST_POS_SUM  = 3'd3;
   localparam logic [2:0] DST_NORM_SUM = 3'd4;

   localparam logic [STEP_WIDTH-1:0] DELTA_BASE = 7'd6;
   localparam logic [STEP_WIDTH-1:0] DELTA_END  = 7'd54;
   localparam logic [STEP_WIDTH-1:0] BLEND_BASE = 7'd55;
   localparam logic [STEP_WIDTH-1:0] BLEND_END  = 7'd76;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP  = 7'd77;

   localparam logic signed [ACC_WIDTH-1:0] VALUE_MAX = ACC_WIDTH'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] VALUE_MIN = -VALUE_MAX - 1;
   localparam logic signed [SUM_WIDTH:0]   SUM_MAX   = (SUM_WIDTH+1)'((64'sd1 <<< (SUM_WIDTH - 1)) - 1);
   localparam logic signed [SUM_WIDTH:0]   SUM_MIN   = -SUM_MAX - 1;
   localparam logic signed [SUM_WIDTH-1:0] OUT_MAX   = SUM_WIDTH'((64'sd1 <<< (OUT_WIDTH - 1)) - 1);
   localparam logic signed [SUM_WIDTH-1:0] OUT_MIN   = -OUT_MAX - 1;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]           cmd;
      logic [BONE_WIDTH-1:0]          bone_index;
      logic [ELEM_WIDTH-1:0]          element_index;
      logic signed [DATA_WIDTH-1:0]   matrix_value;
      logic signed [DATA_WIDTH-1:0]   rest_pos_x;
      logic signed [DATA_WIDTH-1:0]   rest_pos_y;
      logic signed [DATA_WIDTH-1:0]   rest_pos_z;
      logic signed [DATA_WIDTH-1:0]   rest_norm_x;
      logic signed [DATA_WIDTH-1:0]   rest_norm_y;
      logic signed [DATA_WIDTH-1:0]   rest_norm_z;
      logic [WEIGHT_WIDTH-1:0]        weight;
      logic                           last_attachment;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] src;
      logic       use_normal;
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] k;
      logic       frac16;
      logic       first;
      logic       last;
      logic [2:0] dest;
   } op_type;

   function automatic op_type decode_step(input logic [STEP_WIDTH-1:0] step);
      op_type op;
      logic [STEP_WIDTH-1:0] d;
      logic [3:0] e;
      logic [4:0] p;
      logic [1:0] i;
      logic [1:0] j;
      logic [2:0] r;
      op = '0;
      d = '0;
      e = '0;
      p = '0;
      i = '0;
      j = '0;
      r = '0;
      if (step < 7'd3) begin
         op.valid = 1'b1;
         op.src   = SRC_INPUT;
         op.row   = step[1:0];
         op.first = 1'b1;
         op.last  = 1'b1;
         op.dest  = DST_WPOS;
      end else if (step < DELTA_BASE) begin
         d = step - 7'd3;
         op.valid      = 1'b1;
         op.src        = SRC_INPUT;
         op.use_normal = 1'b1;
         op.row        = d[1:0];
         op.first      = 1'b1;
         op.last       = 1'b1;
         op.dest       = DST_WNORM;
      end else if (step < DELTA_END) begin
         d = step - DELTA_BASE;
         e = d[5:2];
         i = (e >= 4'd9) ? 2'd3 : (e >= 4'd6) ? 2'd2 : (e >= 4'd3) ? 2'd1 : 2'd0;
         j = 2'(int'(e) - 3 * int'(i));
         op.valid  = 1'b1;
         op.src    = SRC_MATRIX;
         op.row    = i;
         op.col    = j;
         op.k      = d[1:0];
         op.frac16 = 1'b1;
         op.first  = (d[1:0] == 2'd0);
         op.last   = (d[1:0] == 2'd3);
         op.dest   = DST_DELTA;
      end else if (step >= BLEND_BASE && step < BLEND_END) begin
         d = step - BLEND_BASE;
         p = d[4:0];
         j = (p >= 5'd14) ? 2'd2 : (p >= 5'd7) ? 2'd1 : 2'd0;
         r = 3'(int'(p) - 7 * int'(j));
         op.valid = 1'b1;
         op.col   = j;
         if (r == 3'd0) begin
            op.src   = SRC_TRANSLATE;
            op.row   = 2'd3;
            op.first = 1'b1;
            op.dest  = DST_POS_SUM;
         end else if (r < 3'd4) begin
            op.src    = SRC_LINEAR;
            op.row    = 2'(r - 3'd1);
            op.frac16 = 1'b1;
            op.last   = (r == 3'd3);
            op.dest   = DST_POS_SUM;
         end else begin
            op.src        = SRC_LINEAR;
            op.use_normal = 1'b1;
            op.row        = 2'(r - 3'd4);
            op.frac16     = 1'b1;
            op.first      = (r == 3'd4);
            op.last       = (r == 3'd6);
            op.dest       = DST_NORM_SUM;
         end
      end
      return op;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_value(
      input logic signed [ACC_WIDTH-1:0] v);
      logic signed [ACC_WIDTH-1:0] c;
      c = v;
      if (v > VALUE_MAX) c = VALUE_MAX;
      if (v < VALUE_MIN) c = VALUE_MIN;
      return c[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] sat_sum(
      input logic signed [SUM_WIDTH:0] v);
      logic signed [SUM_WIDTH:0] c;
      c = v;
      if (v > SUM_MAX) c = SUM_MAX;
      if (v < SUM_MIN) c = SUM_MIN;
      return c[SUM_WIDTH-1:0];
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] sat_out(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] c;
      c = v;
      if (v > OUT_MAX) c = OUT_MAX;
      if (v < OUT_MIN) c = OUT_MIN;
      return c[OUT_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/lbs_front.sv =====
// Front end: accepts and classifies input transactions and queues them for the back end.
module lbs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lbs_pkg::item_type   req_item,
   output logic                q_valid,
   output lbs_pkg::item_type   q_item,
   input  logic                q_pop
);

   localparam int PTR_WIDTH = (lbs_pkg::QUEUE_DEPTH > 1) ? $clog2(lbs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(lbs_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(lbs_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(lbs_pkg::QUEUE_DEPTH);

   lbs_pkg::item_type      queue_ff [lbs_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   keep;
   logic                   push;
   logic                   bone_ok;

   assign bone_ok = (int'(req_item.bone_index) < lbs_pkg::BONE_COUNT);

   always_comb begin
      case (req_item.cmd)
         lbs_pkg::CMD_LOAD_WORLD, lbs_pkg::CMD_LOAD_INV: keep = bone_ok;
         lbs_pkg::CMD_ATTACH:                            keep = 1'b1;
         default:                                        keep = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == CNT_FULL);
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/lbs_back.sv =====
// Back end: matrix tables, shared multiplier sequencer, blend sums and result register.
module lbs_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  lbs_pkg::item_type                      q_item,
   output logic                                   q_pop,
   input  logic [lbs_pkg::WEIGHT_WIDTH-1:0]       threshold,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_pos_x,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_pos_y,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_pos_z,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_norm_x,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_norm_y,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]   rsp_skinned_norm_z
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int DW = lbs_pkg::DATA_WIDTH;
   localparam int OW = lbs_pkg::OPND_WIDTH;
   localparam int PW = lbs_pkg::PROD_WIDTH;
   localparam int AW = lbs_pkg::ACC_WIDTH;
   localparam int SW = lbs_pkg::SUM_WIDTH;

   logic [1:0]                          state_ff, state_in;
   logic [lbs_pkg::STEP_WIDTH-1:0]      step_ff, step_in;
   logic [lbs_pkg::BONE_WIDTH-1:0]      bone_ff;
   logic [lbs_pkg::WEIGHT_WIDTH-1:0]    weight_ff;
   logic                                last_ff;
   logic                                use_norm_ff;
   logic signed [DW-1:0]                pos_ff [3];
   logic signed [DW-1:0]                norm_ff [3];
   logic signed [DW-1:0]                wpos_ff [3];
   logic signed [DW-1:0]                wnorm_ff [3];
   logic signed [DW-1:0]                delta_ff [12];
   logic signed [SW-1:0]                sum_ff [6];
   logic signed [DW-1:0]                world_mem [lbs_pkg::BONE_COUNT * 16];
   logic signed [DW-1:0]                inv_mem [lbs_pkg::BONE_COUNT * 16];
   logic signed [DW-1:0]                world_rd_ff;
   logic signed [DW-1:0]                inv_rd_ff;
   lbs_pkg::op_type                     op0, op1_ff, op2_ff;
   logic signed [OW-1:0]                opnd_a, opnd_b;
   logic signed [PW-1:0]                prod_ff;
   logic signed [PW-1:0]                rnd_full;
   logic signed [PW-1:0]                rnd_shift;
   logic signed [AW-1:0]                acc_ff, acc_in;
   logic signed [SW:0]                  sum_next;
   logic [2:0]                          sum_idx;
   logic [3:0]                          delta_rd_idx, delta_wr_idx;
   logic [lbs_pkg::ADDR_WIDTH-1:0]      wr_addr, world_rd_addr, inv_rd_addr;
   logic                                item_bone_ok;
   logic                                emit_fire;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [lbs_pkg::OUT_WIDTH-1:0] out_ff [6];

   assign item_bone_ok = (int'(q_item.bone_index) < lbs_pkg::BONE_COUNT);
   assign q_pop        = (state_ff == ST_IDLE) && q_valid;
   assign emit_fire    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = emit_fire || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_item.cmd == lbs_pkg::CMD_ATTACH) begin
               step_in = '0;
               if (item_bone_ok) begin
                  state_in = ST_RUN;
               end else if (q_item.last_attachment) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == lbs_pkg::LAST_STEP) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         op1_ff       <= '0;
         op2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op1_ff       <= op0;
         op2_ff       <= op1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.cmd == lbs_pkg::CMD_ATTACH) begin
         bone_ff     <= q_item.bone_index;
         weight_ff   <= q_item.weight;
         last_ff     <= q_item.last_attachment;
         use_norm_ff <= (q_item.weight >= threshold);
         pos_ff[0]   <= q_item.rest_pos_x;
         pos_ff[1]   <= q_item.rest_pos_y;
         pos_ff[2]   <= q_item.rest_pos_z;
         norm_ff[0]  <= q_item.rest_norm_x;
         norm_ff[1]  <= q_item.rest_norm_y;
         norm_ff[2]  <= q_item.rest_norm_z;
      end
   end

   // Issue stage: table reads for the matrix product.
   assign op0           = (state_ff == ST_RUN) ? lbs_pkg::decode_step(step_ff) : '0;
   assign wr_addr       = lbs_pkg::ADDR_WIDTH'({q_item.bone_index, q_item.element_index});
   assign inv_rd_addr   = lbs_pkg::ADDR_WIDTH'({bone_ff, op0.row, op0.k});
   assign world_rd_addr = lbs_pkg::ADDR_WIDTH'({bone_ff, op0.k, op0.col});

   always_ff @(posedge clock) begin
      if (q_pop && q_item.cmd == lbs_pkg::CMD_LOAD_WORLD) begin
         world_mem[wr_addr] <= q_item.matrix_value;
      end
      world_rd_ff <= world_mem[world_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.cmd == lbs_pkg::CMD_LOAD_INV) begin
         inv_mem[wr_addr] <= q_item.matrix_value;
      end
      inv_rd_ff <= inv_mem[inv_rd_addr];
   end

   // Multiply stage.
   assign delta_rd_idx = 4'({2'b00, op1_ff.row} * 4'd3 + {2'b00, op1_ff.col});

   always_comb begin
      opnd_a = '0;
      opnd_b = '0;
      unique case (op1_ff.src)
         lbs_pkg::SRC_INPUT: begin
            opnd_a = OW'({1'b0, weight_ff});
            opnd_b = op1_ff.use_normal ? OW'(norm_ff[op1_ff.row]) : OW'(pos_ff[op1_ff.row]);
         end
         lbs_pkg::SRC_MATRIX: begin
            opnd_a = OW'(inv_rd_ff);
            opnd_b = OW'(world_rd_ff);
         end
         lbs_pkg::SRC_TRANSLATE: begin
            opnd_a = OW'({1'b0, weight_ff});
            opnd_b = OW'(delta_ff[delta_rd_idx]);
         end
         lbs_pkg::SRC_LINEAR: begin
            opnd_a = op1_ff.use_normal ? OW'(wnorm_ff[op1_ff.row]) : OW'(wpos_ff[op1_ff.row]);
            opnd_b = OW'(delta_ff[delta_rd_idx]);
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opnd_a * opnd_b;
   end

   // Round, ties away from zero, and accumulate.
   always_comb begin
      rnd_full  = prod_ff + (op2_ff.frac16 ? PW'(64'd32768) : PW'(64'd16384))
                  - PW'({1'b0, prod_ff[PW-1]});
      rnd_shift = op2_ff.frac16 ? (rnd_full >>> 16) : (rnd_full >>> 15);
      acc_in    = (op2_ff.first ? '0 : acc_ff) + rnd_shift[AW-1:0];
   end

   assign delta_wr_idx = 4'({2'b00, op2_ff.row} * 4'd3 + {2'b00, op2_ff.col});
   assign sum_idx      = (op2_ff.dest == lbs_pkg::DST_NORM_SUM) ? 3'd3 + {1'b0, op2_ff.col}
                                                                : {1'b0, op2_ff.col};
   assign sum_next     = (SW+1)'(sum_ff[sum_idx]) + (SW+1)'(acc_in);

   always_ff @(posedge clock) begin
      if (op2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (op2_ff.valid && op2_ff.last) begin
         case (op2_ff.dest)
            lbs_pkg::DST_WPOS:  wpos_ff[op2_ff.row]    <= lbs_pkg::sat_value(acc_in);
            lbs_pkg::DST_WNORM: wnorm_ff[op2_ff.row]   <= lbs_pkg::sat_value(acc_in);
            lbs_pkg::DST_DELTA: delta_ff[delta_wr_idx] <= lbs_pkg::sat_value(acc_in);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit_fire) begin
         for (int s = 0; s < 6; s++) begin
            sum_ff[s] <= '0;
         end
      end else if (op2_ff.valid && op2_ff.last) begin
         if (op2_ff.dest == lbs_pkg::DST_POS_SUM ||
             (op2_ff.dest == lbs_pkg::DST_NORM_SUM && use_norm_ff)) begin
            sum_ff[sum_idx] <= lbs_pkg::sat_sum(sum_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         for (int s = 0; s < 6; s++) begin
            out_ff[s] <= lbs_pkg::sat_out(sum_ff[s]);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_skinned_pos_x  = out_ff[0];
   assign rsp_skinned_pos_y  = out_ff[1];
   assign rsp_skinned_pos_z  = out_ff[2];
   assign rsp_skinned_norm_x = out_ff[3];
   assign rsp_skinned_norm_y = out_ff[4];
   assign rsp_skinned_norm_z = out_ff[5];

`ifndef NO_ASSERTIONS
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("Result raised outside the emit state.");
   a_op_from_run: assert property (@(posedge clock) disable iff (reset)
      op2_ff.valid |-> $past(state_ff == ST_RUN, 2))
      else $error("Operation retired without a running transaction.");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> step_ff <= lbs_pkg::LAST_STEP)
      else $error("Step counter ran past the schedule.");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Queue popped while empty.");
`endif

endmodule

// ===== rtl/linear_blend_skinning.sv =====
// Top level of the linear blend skinning block.
// A load is written to its table as it leaves the queue; an attachment leaves the queue, then issues 75
// multiplier products, with an idle slot before the blend terms, followed by a pipeline drain.
// A last attachment then passes through the emit state, which registers the result and raises its valid.
// A two-entry queue takes input meanwhile; a stalled result holds the back end only at its next emit.
// Reset clears the queue, sums and result valid flag and sets the threshold to 9830, not the tables.
module linear_blend_skinning (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [lbs_pkg::CMD_WIDTH-1:0]           req_cmd,
   input  logic [lbs_pkg::BONE_WIDTH-1:0]          req_bone_index,
   input  logic [lbs_pkg::ELEM_WIDTH-1:0]          req_element_index,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_matrix_value,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_pos_x,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_pos_y,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_pos_z,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_norm_x,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_norm_y,
   input  logic signed [lbs_pkg::DATA_WIDTH-1:0]   req_rest_norm_z,
   input  logic [lbs_pkg::WEIGHT_WIDTH-1:0]        req_weight,
   input  logic                                    req_last_attachment,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_pos_x,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_pos_y,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_pos_z,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_norm_x,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_norm_y,
   output logic signed [lbs_pkg::OUT_WIDTH-1:0]    rsp_skinned_norm_z,
   input  logic                                    csr_wr_en,
   input  logic [lbs_pkg::WEIGHT_WIDTH-1:0]        csr_wr_data
);

   localparam logic [lbs_pkg::WEIGHT_WIDTH-1:0] THRESHOLD_RESET = 16'd9830;

   lbs_pkg::item_type                  req_item;
   lbs_pkg::item_type                  q_item;
   logic                               q_valid;
   logic                               q_pop;
   logic [lbs_pkg::WEIGHT_WIDTH-1:0]   threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_comb begin
      req_item.cmd             = req_cmd;
      req_item.bone_index      = req_bone_index;
      req_item.element_index   = req_element_index;
      req_item.matrix_value    = req_matrix_value;
      req_item.rest_pos_x      = req_rest_pos_x;
      req_item.rest_pos_y      = req_rest_pos_y;
      req_item.rest_pos_z      = req_rest_pos_z;
      req_item.rest_norm_x     = req_rest_norm_x;
      req_item.rest_norm_y     = req_rest_norm_y;
      req_item.rest_norm_z     = req_rest_norm_z;
      req_item.weight          = req_weight;
      req_item.last_attachment = req_last_attachment;
   end

   lbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   lbs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .threshold          (threshold_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_skinned_pos_x  (rsp_skinned_pos_x),
      .rsp_skinned_pos_y  (rsp_skinned_pos_y),
      .rsp_skinned_pos_z  (rsp_skinned_pos_z),
      .rsp_skinned_norm_x (rsp_skinned_norm_x),
      .rsp_skinned_norm_y (rsp_skinned_norm_y),
      .rsp_skinned_norm_z (rsp_skinned_norm_z)
   );

endmodule
